[hdl/wlms_pkg.sv]
`default_nettype none

package wlms_pkg;

    // defaults for the top-level parameters
    localparam int MAX_HALF_BINS_DEF = 25;
    localparam int POS_BITS_DEF      = 22;

    // fixed field widths
    localparam int SEQ_BITS   = 22;
    localparam int SCORE_BITS = 32;
    localparam int CFG_BITS   = 5;

    localparam logic [CFG_BITS-1:0] HALF_WIN_RESET = 5'd25;

    // flags per popcount group in the reduction tree
    localparam int GRP_SIZE = 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_PRUNE,
        ST_FLUSH,
        ST_END
    } t_state;

    // what travels down the peak-test pipe
    typedef enum logic [1:0] {
        TK_NONE,
        TK_CAND,
        TK_MARK,
        TK_END
    } t_tok;

    typedef struct packed {
        logic clear;
        logic shift;
        logic load;
        logic mark;
    } t_cell_ctl;

    typedef struct packed {
        logic gt;
        logic eq;
        logic below;
    } t_flags;

endpackage

`default_nettype wire

[hdl/wlms_cell.sv]
`default_nettype none

module wlms_cell import wlms_pkg::*; #(
    parameter int POS_BITS = POS_BITS_DEF,
    parameter int H_BITS   = $clog2(MAX_HALF_BINS_DEF + 1)
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire t_cell_ctl                    i_ctl,
    // right-hand neighbor, taken on a shift
    input  wire logic                         i_nb_valid,
    input  wire logic                         i_nb_dec,
    input  wire logic [POS_BITS-1:0]          i_nb_pos,
    input  wire logic signed [SCORE_BITS-1:0] i_nb_score,
    input  wire logic [SEQ_BITS-1:0]          i_nb_seq,
    // new bin, taken on a load
    input  wire logic [POS_BITS-1:0]          i_new_pos,
    input  wire logic signed [SCORE_BITS-1:0] i_new_score,
    input  wire logic [SEQ_BITS-1:0]          i_new_seq,
    // broadcast candidate under test
    input  wire logic [POS_BITS-1:0]          i_cand_pos,
    input  wire logic signed [SCORE_BITS-1:0] i_cand_score,
    input  wire logic [H_BITS-1:0]            i_h,
    output logic                              o_valid,
    output logic                              o_dec,
    output logic [POS_BITS-1:0]               o_pos,
    output logic signed [SCORE_BITS-1:0]      o_score,
    output logic [SEQ_BITS-1:0]               o_seq,
    output t_flags                            o_flags
);

    localparam int PW = POS_BITS + 1;

    logic                         r_valid;
    logic                         r_dec;
    logic [POS_BITS-1:0]          r_pos;
    logic signed [SCORE_BITS-1:0] r_score;
    logic [SEQ_BITS-1:0]          r_seq;
    t_flags                       r_flags;
    t_flags                       n_flags;

    logic [PW-1:0] w_pos_x;
    logic [PW-1:0] w_cand_x;
    logic [PW-1:0] w_h_x;
    logic          w_in_win;

    assign w_pos_x  = {1'b0, r_pos};
    assign w_cand_x = {1'b0, i_cand_pos};
    assign w_h_x    = PW'(i_h);

    // neighbor test; equal position means the candidate itself
    always_comb begin
        w_in_win = r_valid && (r_pos != i_cand_pos) &&
                   (w_pos_x + w_h_x >= w_cand_x) && (w_pos_x <= w_cand_x + w_h_x);
        n_flags.gt    = w_in_win && (r_score > i_cand_score);
        n_flags.eq    = w_in_win && (r_score == i_cand_score);
        n_flags.below = n_flags.eq && (r_pos < i_cand_pos);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_dec   <= 1'b0;
        end else if (i_en) begin
            if (i_ctl.clear) begin
                r_valid <= 1'b0;
                r_dec   <= 1'b0;
            end else if (i_ctl.shift) begin
                r_valid <= i_nb_valid;
                r_dec   <= i_nb_dec;
            end else if (i_ctl.load) begin
                r_valid <= 1'b1;
                r_dec   <= 1'b0;
            end else if (i_ctl.mark) begin
                r_dec   <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_flags <= n_flags;
            if (i_ctl.shift) begin
                r_pos   <= i_nb_pos;
                r_score <= i_nb_score;
                r_seq   <= i_nb_seq;
            end else if (i_ctl.load) begin
                r_pos   <= i_new_pos;
                r_score <= i_new_score;
                r_seq   <= i_new_seq;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_dec   = r_dec;
    assign o_pos   = r_pos;
    assign o_score = r_score;
    assign o_seq   = r_seq;
    assign o_flags = r_flags;

endmodule

`default_nettype wire

[hdl/wlms_reduce.sv]
`default_nettype none

module wlms_reduce import wlms_pkg::*; #(
    parameter int DEPTH = 2 * MAX_HALF_BINS_DEF + 1
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_en,
    input  wire t_flags [DEPTH-1:0]           i_flags,
    output logic                              o_any_gt,
    output logic [$clog2(DEPTH + 1)-1:0]      o_eq_cnt,
    output logic [$clog2(DEPTH + 1)-1:0]      o_below_cnt
);

    localparam int NGRP = (DEPTH + GRP_SIZE - 1) / GRP_SIZE;
    localparam int PADW = NGRP * GRP_SIZE;
    localparam int GW   = $clog2(GRP_SIZE + 1);
    localparam int CW   = $clog2(DEPTH + 1);

    logic [PADW-1:0] w_eq_pad;
    logic [PADW-1:0] w_below_pad;
    logic [PADW-1:0] w_gt_pad;

    logic [GW-1:0]   n_grp_eq    [NGRP];
    logic [GW-1:0]   n_grp_below [NGRP];
    logic [NGRP-1:0] n_grp_gt;
    logic [GW-1:0]   r_grp_eq    [NGRP];
    logic [GW-1:0]   r_grp_below [NGRP];
    logic [NGRP-1:0] r_grp_gt;

    always_comb begin
        w_eq_pad    = '0;
        w_below_pad = '0;
        w_gt_pad    = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_eq_pad[i]    = i_flags[i].eq;
            w_below_pad[i] = i_flags[i].below;
            w_gt_pad[i]    = i_flags[i].gt;
        end
    end

    // first level: one small count per group of cells
    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            n_grp_eq[g]    = '0;
            n_grp_below[g] = '0;
            n_grp_gt[g]    = 1'b0;
            for (int b = 0; b < GRP_SIZE; b++) begin
                n_grp_eq[g]    = n_grp_eq[g]    + GW'(w_eq_pad[g*GRP_SIZE + b]);
                n_grp_below[g] = n_grp_below[g] + GW'(w_below_pad[g*GRP_SIZE + b]);
                n_grp_gt[g]    = n_grp_gt[g]    | w_gt_pad[g*GRP_SIZE + b];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_grp_eq    <= n_grp_eq;
            r_grp_below <= n_grp_below;
            r_grp_gt    <= n_grp_gt;
        end
    end

    // second level: sum of group counts
    always_comb begin
        o_eq_cnt    = '0;
        o_below_cnt = '0;
        for (int g = 0; g < NGRP; g++) begin
            o_eq_cnt    = o_eq_cnt    + CW'(r_grp_eq[g]);
            o_below_cnt = o_below_cnt + CW'(r_grp_below[g]);
        end
        o_any_gt = |r_grp_gt;
    end

endmodule

`default_nettype wire

[hdl/window_local_maximum_select.sv]
`default_nettype none

// Sliding-window local-maximum picker. Bins come in on the input channel in
// strictly rising bin order, each with a signed Q16.16 score; a bin is reported
// as a peak when no stored bin within +/- H bins has a higher score and, among
// equal-score bins in that range, it is the upper median by position. H is the
// half_window_bins register (written through i_cfg_we / i_cfg_wdata, reset 25)
// clamped to 1..MAX_HALF_BINS; write it only while the block is idle. A bin is
// decided once a later bin lands beyond pos+H, or when an item with last_item
// set arrives; that item ends its output with a closing marker beat
// (is_peak=0, stream_done=1) and resets the window and sequence numbering.
// Items that do not rise in position still get a sequence number but are not
// stored. last_of_run flags the final beat caused by an input item; an item
// may cause no beat at all. Both channels are valid/ready.
// Flow: one item at a time. The window is a row of 2*MAX_HALF_BINS+1 cells;
// each decided bin is issued into a 3-stage peak-test pipe (broadcast compare
// in the cells, group popcount, final sum), and each bin that ages out of the
// window is shifted out of the row. A rising item is stored after its decided
// bins are issued and its aged-out bins dropped; a last item then issues its
// remaining bins and the closing marker. An item's final beat, the one with
// last_of_run, is sent when the item's end token leaves the pipe; earlier beats
// are held until the next one is known. The whole engine stalls while an output
// beat waits to be taken.

module window_local_maximum_select import wlms_pkg::*; #(
    parameter int MAX_HALF_BINS = MAX_HALF_BINS_DEF,
    parameter int POS_BITS      = POS_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // configuration
    input  wire logic                         i_cfg_we,
    input  wire logic [CFG_BITS-1:0]          i_cfg_wdata,
    // input channel
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic [POS_BITS-1:0]          i_bin_pos,
    input  wire logic signed [SCORE_BITS-1:0] i_z_score,
    input  wire logic                         i_last_item,
    // output channel
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic [SEQ_BITS-1:0]               o_peak_index,
    output logic [POS_BITS-1:0]               o_peak_pos,
    output logic                              o_is_peak,
    output logic                              o_last_of_run,
    output logic                              o_stream_done
);

    localparam int DEPTH   = 2 * MAX_HALF_BINS + 1;
    localparam int H_BITS  = $clog2(MAX_HALF_BINS + 1);
    localparam int PW      = POS_BITS + 1;
    localparam int CW      = $clog2(DEPTH + 1);
    localparam int MAX_RES = MAX_HALF_BINS + 2;
    localparam int RW      = $clog2(MAX_RES + 1);

    // ------------------------------------------------------------------
    // config and input capture
    // ------------------------------------------------------------------
    logic [CFG_BITS-1:0]          r_cfg;
    logic [H_BITS-1:0]            w_h_sat;
    logic [H_BITS-1:0]            r_h;
    logic [SEQ_BITS-1:0]          r_count;
    logic [POS_BITS-1:0]          r_in_pos;
    logic signed [SCORE_BITS-1:0] r_in_score;
    logic [SEQ_BITS-1:0]          r_in_seq;
    logic                         r_in_last;
    logic                         w_accept;

    t_state r_state;
    t_state n_state;

    // FSM outputs
    t_tok w_issue;
    logic w_mark;
    logic w_shift;
    logic w_load;
    logic w_clear;

    // engine advance: output register free or being emptied
    logic w_adv;

    // ------------------------------------------------------------------
    // cell row; index DEPTH is an always-empty cell past the tail
    // ------------------------------------------------------------------
    logic [DEPTH:0]               w_valid;
    logic [DEPTH:0]               w_dec;
    logic [POS_BITS-1:0]          w_pos   [DEPTH+1];
    logic signed [SCORE_BITS-1:0] w_score [DEPTH+1];
    logic [SEQ_BITS-1:0]          w_seq   [DEPTH+1];
    t_flags [DEPTH-1:0]           w_flags;
    t_cell_ctl                    w_ctl   [DEPTH];

    logic [DEPTH-1:0] w_first;   // first undecided bin
    logic [DEPTH-1:0] w_lastv;   // newest stored bin
    logic [DEPTH-1:0] w_slot;    // where a new bin goes

    logic [POS_BITS-1:0]          w_sel_pos;
    logic signed [SCORE_BITS-1:0] w_sel_score;
    logic [SEQ_BITS-1:0]          w_sel_seq;
    logic [POS_BITS-1:0]          w_last_pos;
    logic                         w_has_undec;
    logic                         w_decide_ok;
    logic                         w_prune_ok;
    logic                         w_rising;

    // ------------------------------------------------------------------
    // peak-test pipe
    // ------------------------------------------------------------------
    t_tok                         r_c_kind;
    logic [POS_BITS-1:0]          r_c_pos;
    logic signed [SCORE_BITS-1:0] r_c_score;
    logic [SEQ_BITS-1:0]          r_c_seq;
    logic                         r_c_last;
    t_tok                         r_s1_kind;
    logic [POS_BITS-1:0]          r_s1_pos;
    logic [SEQ_BITS-1:0]          r_s1_seq;
    logic                         r_s1_last;
    t_tok                         r_s2_kind;
    logic [POS_BITS-1:0]          r_s2_pos;
    logic [SEQ_BITS-1:0]          r_s2_seq;
    logic                         r_s2_last;

    logic          w_any_gt;
    logic [CW-1:0] w_eq_cnt;
    logic [CW-1:0] w_below_cnt;
    logic [CW-1:0] w_ties;
    logic          w_cand_peak;
    logic [RW-1:0] w_limit;

    // ------------------------------------------------------------------
    // result staging: one held beat so last_of_run is known before it leaves
    // ------------------------------------------------------------------
    logic [RW-1:0]       r_cnt;
    logic                w_count_up;
    logic                w_new_res;
    logic                w_flush;
    logic                w_move;
    logic [SEQ_BITS-1:0] w_new_idx;
    logic [POS_BITS-1:0] w_new_pos;
    logic                w_new_peak;
    logic                w_new_done;

    logic                r_pd_valid;
    logic [SEQ_BITS-1:0] r_pd_idx;
    logic [POS_BITS-1:0] r_pd_pos;
    logic                r_pd_peak;
    logic                r_pd_done;

    logic                r_ov;
    logic [SEQ_BITS-1:0] r_o_idx;
    logic [POS_BITS-1:0] r_o_pos;
    logic                r_o_peak;
    logic                r_o_lor;
    logic                r_o_done;

    assign w_adv    = !r_ov || i_out_ready;
    assign w_accept = i_in_valid && o_in_ready;

    // clamp of the half window
    always_comb begin
        if (r_cfg == '0) begin
            w_h_sat = H_BITS'(1);
        end else if (r_cfg > CFG_BITS'(MAX_HALF_BINS)) begin
            w_h_sat = H_BITS'(MAX_HALF_BINS);
        end else begin
            w_h_sat = H_BITS'(r_cfg);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg   <= HALF_WIN_RESET;
            r_count <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            if (w_accept) begin
                r_count <= i_last_item ? '0 : r_count + SEQ_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_pos   <= i_bin_pos;
            r_in_score <= i_z_score;
            r_in_seq   <= r_count;
            r_in_last  <= i_last_item;
            r_h        <= w_h_sat;
        end
    end

    // ------------------------------------------------------------------
    // cells
    // ------------------------------------------------------------------
    assign w_valid[DEPTH] = 1'b0;
    assign w_dec[DEPTH]   = 1'b0;
    assign w_pos[DEPTH]   = '0;
    assign w_score[DEPTH] = '0;
    assign w_seq[DEPTH]   = '0;

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        if (k == 0) begin : g_head
            assign w_first[k] = w_valid[k] & ~w_dec[k];
            assign w_slot[k]  = ~w_valid[k];
        end else begin : g_body
            // decided bins form a prefix of the stored ones
            assign w_first[k] = w_valid[k] & ~w_dec[k] & w_dec[k-1];
            assign w_slot[k]  = ~w_valid[k] & w_valid[k-1];
        end
        assign w_lastv[k] = w_valid[k] & ~w_valid[k+1];

        assign w_ctl[k] = '{clear: w_clear,
                            shift: w_shift,
                            load:  w_load & w_slot[k],
                            mark:  w_mark & w_first[k]};

        wlms_cell #(
            .POS_BITS (POS_BITS),
            .H_BITS   (H_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_en         (w_adv),
            .i_ctl        (w_ctl[k]),
            .i_nb_valid   (w_valid[k+1]),
            .i_nb_dec     (w_dec[k+1]),
            .i_nb_pos     (w_pos[k+1]),
            .i_nb_score   (w_score[k+1]),
            .i_nb_seq     (w_seq[k+1]),
            .i_new_pos    (r_in_pos),
            .i_new_score  (r_in_score),
            .i_new_seq    (r_in_seq),
            .i_cand_pos   (r_c_pos),
            .i_cand_score (r_c_score),
            .i_h          (r_h),
            .o_valid      (w_valid[k]),
            .o_dec        (w_dec[k]),
            .o_pos        (w_pos[k]),
            .o_score      (w_score[k]),
            .o_seq        (w_seq[k]),
            .o_flags      (w_flags[k])
        );
    end

    // one-hot picks of the first undecided bin and of the newest bin
    always_comb begin
        w_sel_pos   = '0;
        w_sel_score = '0;
        w_sel_seq   = '0;
        w_last_pos  = '0;
        for (int k = 0; k < DEPTH; k++) begin
            w_sel_pos   = w_sel_pos   | (w_pos[k]   & {POS_BITS{w_first[k]}});
            w_sel_score = w_sel_score | (w_score[k] & {SCORE_BITS{w_first[k]}});
            w_sel_seq   = w_sel_seq   | (w_seq[k]   & {SEQ_BITS{w_first[k]}});
            w_last_pos  = w_last_pos  | (w_pos[k]   & {POS_BITS{w_lastv[k]}});
        end
        w_has_undec = |w_first;
    end

    // bin falls left of the new bin's reach / ages out of the window
    assign w_decide_ok = w_has_undec &&
                         ({1'b0, w_sel_pos} + PW'(r_h) < {1'b0, r_in_pos});
    assign w_prune_ok  = w_valid[0] &&
                         ({1'b0, w_pos[0]} + PW'({r_h, 1'b0}) < {1'b0, r_in_pos});
    assign w_rising    = !w_valid[0] || (r_in_pos > w_last_pos);

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else if (r_state == ST_IDLE || w_adv) begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (!w_decide_ok) begin
                    if (w_rising)       n_state = ST_PRUNE;
                    else if (r_in_last) n_state = ST_FLUSH;
                    else                n_state = ST_IDLE;
                end
            end
            ST_PRUNE: begin
                if (!w_prune_ok) n_state = r_in_last ? ST_FLUSH : ST_IDLE;
            end
            ST_FLUSH: begin
                if (!w_has_undec) n_state = ST_END;
            end
            ST_END: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        w_issue    = TK_NONE;
        w_mark     = 1'b0;
        w_shift    = 1'b0;
        w_load     = 1'b0;
        w_clear    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
            end
            ST_DECIDE: begin
                if (w_decide_ok) begin
                    w_issue = TK_CAND;
                    w_mark  = 1'b1;
                end else if (!w_rising && !r_in_last) begin
                    w_issue = TK_END;
                end
            end
            ST_PRUNE: begin
                if (w_prune_ok) begin
                    w_shift = 1'b1;
                end else begin
                    w_load = 1'b1;
                    if (!r_in_last) w_issue = TK_END;
                end
            end
            ST_FLUSH: begin
                if (w_has_undec) begin
                    w_issue = TK_CAND;
                    w_mark  = 1'b1;
                end else begin
                    // last candidate leaves for the cells on this same edge
                    w_issue = TK_MARK;
                    w_clear = 1'b1;
                end
            end
            ST_END: begin
                w_issue = TK_END;
            end
            default: begin
                w_issue = TK_NONE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // peak-test pipe: S0 broadcast, S1 cell flags, S2 group counts
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_kind  <= TK_NONE;
            r_s1_kind <= TK_NONE;
            r_s2_kind <= TK_NONE;
        end else if (w_adv) begin
            r_c_kind  <= w_issue;
            r_s1_kind <= r_c_kind;
            r_s2_kind <= r_s1_kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_c_pos   <= w_sel_pos;
            r_c_score <= w_sel_score;
            r_c_seq   <= w_sel_seq;
            r_c_last  <= r_in_last;
            r_s1_pos  <= r_c_pos;
            r_s1_seq  <= r_c_seq;
            r_s1_last <= r_c_last;
            r_s2_pos  <= r_s1_pos;
            r_s2_seq  <= r_s1_seq;
            r_s2_last <= r_s1_last;
        end
    end

    wlms_reduce #(
        .DEPTH (DEPTH)
    ) u_reduce (
        .i_clk       (i_clk),
        .i_en        (w_adv),
        .i_flags     (w_flags),
        .o_any_gt    (w_any_gt),
        .o_eq_cnt    (w_eq_cnt),
        .o_below_cnt (w_below_cnt)
    );

    // upper median among ties: floor(ties/2) of them lie below
    assign w_ties      = w_eq_cnt + CW'(1);
    assign w_cand_peak = !w_any_gt && (w_below_cnt == (w_ties >> 1));
    // the closing marker takes the last slot of a final item's burst
    assign w_limit     = r_s2_last ? RW'(MAX_RES - 1) : RW'(MAX_RES);

    always_comb begin
        w_count_up = 1'b0;
        w_new_res  = 1'b0;
        w_flush    = 1'b0;
        w_new_idx  = r_s2_seq;
        w_new_pos  = r_s2_pos;
        w_new_peak = 1'b1;
        w_new_done = 1'b0;
        case (r_s2_kind)
            TK_CAND: begin
                w_count_up = w_cand_peak && (r_cnt < w_limit);
                w_new_res  = w_count_up;
            end
            TK_MARK: begin
                w_new_res  = 1'b1;
                w_new_idx  = '0;
                w_new_pos  = '0;
                w_new_peak = 1'b0;
                w_new_done = 1'b1;
            end
            TK_END: begin
                w_flush = 1'b1;
            end
            default: begin
                w_new_res = 1'b0;
            end
        endcase
    end

    assign w_move = r_pd_valid && (w_new_res || w_flush);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pd_valid <= 1'b0;
            r_ov       <= 1'b0;
            r_cnt      <= '0;
        end else if (w_adv) begin
            r_ov <= w_move;
            if (w_new_res) begin
                r_pd_valid <= 1'b1;
            end else if (w_flush) begin
                r_pd_valid <= 1'b0;
            end
            if (w_flush) begin
                r_cnt <= '0;
            end else if (w_count_up) begin
                r_cnt <= r_cnt + RW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (w_move) begin
                r_o_idx  <= r_pd_idx;
                r_o_pos  <= r_pd_pos;
                r_o_peak <= r_pd_peak;
                r_o_done <= r_pd_done;
                r_o_lor  <= w_flush;
            end
            if (w_new_res) begin
                r_pd_idx  <= w_new_idx;
                r_pd_pos  <= w_new_pos;
                r_pd_peak <= w_new_peak;
                r_pd_done <= w_new_done;
            end
        end
    end

    assign o_out_valid   = r_ov;
    assign o_peak_index  = r_o_idx;
    assign o_peak_pos    = r_o_pos;
    assign o_is_peak     = r_o_peak;
    assign o_last_of_run = r_o_lor;
    assign o_stream_done = r_o_done;

endmodule

`default_nettype wire
